[src/sha_pkg.sv]
// SHA-256 engine package: constants, round table and rotate function.
// No dependencies.
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned Rounds = 64;

  typedef logic [31:0] word_t;

  // entry queued between the front and the back
  typedef struct packed {
    logic [31:0] word;
    logic        pad;   // 1: word carries message end, pad after it
    logic [63:0] bits;  // message length in bits, valid with pad; low 3 bits carry the final byte count
  } job_t;

  typedef enum logic [2:0] {
    StIdle, StLoad, StRound, StFold, StPad, StOut
  } back_st_e;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

[src/sha256_hash_engine.sv]
// SHA-256 engine top: front end, job queue, compression back end.
// Depends on sha_pkg, sha_front, sha_fifo, sha_back.
`default_nettype none
// channel | dir | handshake       | payload
// input   | in  | valid_i/ready_o | data_word_i, byte_count_i, message_end_i
// output  | out | valid_o/ready_i | digest_word_o, word_index_o, digest_last_o
//
// In the back end a word passes the idle and load states; each filled block
// then runs the compression rounds and a fold step in the shared round unit.
// Message end adds padding words and one or two blocks, then 8 digest beats.
// Reset is asynchronous; hash words return to the initial values.
// The front end keeps taking words while the queue (two entries by default) has room.
module sha256_hash_engine
  import sha_pkg::*;
#(
  parameter int unsigned QueueDepth = FifoDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        message_end_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             digest_last_o
);

  job_t in_job, out_job;
  logic push, full, pop, empty;

  sha_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .data_word_i, .byte_count_i,
    .message_end_i, .push_o(push), .job_o(in_job), .full_i(full)
  );

  sha_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_job), .full_o(full),
    .pop_i(pop), .data_o(out_job), .empty_o(empty)
  );

  sha_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(out_job), .pop_o(pop),
    .valid_o, .ready_i, .digest_word_o, .word_index_o, .digest_last_o
  );

endmodule
`default_nettype wire

[src/sha_front.sv]
// Front end: accepts words, masks the final word, counts message length.
// Depends on sha_pkg.
`default_nettype none
module sha_front
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        message_end_i,
  output logic             push_o,
  output job_t             job_o,
  input  wire logic        full_i
);

  logic [60:0] len_q, len_d, len_sum;
  logic [2:0]  cnt;
  logic [31:0] keep;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    cnt = message_end_i ? ((byte_count_i > 3'd4) ? 3'd4 : byte_count_i) : 3'd4;
    unique case (cnt)
      3'd0:    keep = 32'h0;
      3'd1:    keep = 32'hff000000;
      3'd2:    keep = 32'hffff0000;
      3'd3:    keep = 32'hffffff00;
      default: keep = 32'hffffffff;
    endcase
    len_sum = len_q + 61'(cnt);
    len_d   = len_q;
    if (push_o) len_d = message_end_i ? '0 : len_sum;
    job_o.word = data_word_i & keep;
    job_o.pad  = message_end_i;
    job_o.bits = {len_sum, 3'b000};
    // the count rides in the low bits of bits for the back end's pad byte
    if (message_end_i) job_o.bits[2:0] = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule
`default_nettype wire

[src/sha_fifo.sv]
// Small queue between front and back end.
// Depends on sha_pkg.
`default_nettype none
module sha_fifo
  import sha_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  job_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

[src/sha_back.sv]
// Back end: block buffer, padding sequencer, one-round-per-cycle compression
// and digest output. Depends on sha_pkg.
`default_nettype none
module sha_back
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             digest_last_o
);

  back_st_e st_q, st_d;
  word_t w_q [16];
  word_t h_q [8];
  word_t v_q [8];
  logic [3:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        fin_q;     // padding in progress
  logic        lenok_q;   // current message needs length now
  logic        mark_q;    // full final word: 0x80 marker word still owed
  logic [63:0] bits_q;

  // padding generator's word for this cycle's push, and the push strobe
  word_t pw;
  logic  push;
  word_t nw, wt, t1, t2;

  always_comb begin
    word_t a2, a15;
    a2  = w_q[4'(rnd_q - 6'd2)];
    a15 = w_q[4'(rnd_q - 6'd15)];
    nw  = (rotr(a2,17) ^ rotr(a2,19) ^ (a2 >> 10)) + w_q[4'(rnd_q - 6'd7)]
        + (rotr(a15,7) ^ rotr(a15,18) ^ (a15 >> 3)) + w_q[rnd_q[3:0]];
    wt  = (rnd_q >= 6'd16) ? nw : w_q[rnd_q[3:0]];
    t1  = v_q[7] + (rotr(v_q[4],6) ^ rotr(v_q[4],11) ^ rotr(v_q[4],25))
        + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + wt;
    t2  = (rotr(v_q[0],2) ^ rotr(v_q[0],13) ^ rotr(v_q[0],22))
        + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // padding word generator
  always_comb begin
    pw = '0;
    if (mark_q) pw = 32'h80000000;
    else if (lenok_q && fill_q == 4'd14) pw = bits_q[63:32];
    else if (lenok_q && fill_q == 4'd15) pw = {bits_q[31:3], 3'b000};
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (!empty_i) st_d = StLoad;
      StLoad:  st_d = (fill_q == 4'd15) ? StRound : (job_i.pad ? StPad : StIdle);
      StPad:   if (fill_q == 4'd15) st_d = StRound;
      StRound: if (rnd_q == 6'd63) st_d = StFold;
      StFold:  st_d = (fin_q && lenok_q) ? StOut : (fin_q ? StPad : StIdle);
      StOut:   if (ready_i && oidx_q == 3'd7) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    pop_o = (st_q == StLoad);
    push  = (st_q == StLoad) || (st_q == StPad);
    valid_o = (st_q == StOut);
    digest_word_o = h_q[oidx_q];
    word_index_o  = oidx_q;
    digest_last_o = (oidx_q == 3'd7);
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StLoad) begin
      if (job_i.pad) begin
        unique case (job_i.bits[2:0])
          3'd0: w_q[fill_q] <= 32'h80000000;
          3'd1: w_q[fill_q] <= job_i.word | 32'h00800000;
          3'd2: w_q[fill_q] <= job_i.word | 32'h00008000;
          3'd3: w_q[fill_q] <= job_i.word | 32'h00000080;
          default: w_q[fill_q] <= job_i.word;
        endcase
      end else begin
        w_q[fill_q] <= job_i.word;
      end
    end else if (st_q == StPad) begin
      w_q[fill_q] <= pw;
    end else if (st_q == StRound && rnd_q >= 6'd16) begin
      w_q[rnd_q[3:0]] <= nw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      for (int i = 0; i < 8; i++) begin h_q[i] <= InitHash[i]; v_q[i] <= '0; end
      fill_q <= '0; rnd_q <= '0; oidx_q <= '0;
      fin_q <= 1'b0; lenok_q <= 1'b0; mark_q <= 1'b0; bits_q <= '0;
    end else begin
      st_q <= st_d;
      if (push) fill_q <= fill_q + 4'd1;
      if (st_q == StLoad && job_i.pad) begin
        fin_q  <= 1'b1;
        bits_q <= job_i.bits;
        // a full final word still needs a separate 0x80 word before the length
        mark_q <= (job_i.bits[2:0] == 3'd4);
        lenok_q <= (job_i.bits[2:0] == 3'd4) ? (fill_q <= 4'd12) : (fill_q <= 4'd13);
      end
      if (st_q == StPad) mark_q <= 1'b0;
      if (push && fill_q == 4'd15) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
        rnd_q <= '0;
      end
      if (st_q == StRound) begin
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        rnd_q  <= rnd_q + 6'd1;
      end
      if (st_q == StFold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        if (fin_q) lenok_q <= 1'b1;
      end
      if (st_q == StOut && ready_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
          fin_q <= 1'b0; lenok_q <= 1'b0;
        end
      end
    end
  end

  sha_pad_ok_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StPad |-> fin_q) else $error("padding outside message end");
  sha_out_fill_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StOut |-> fill_q == 4'd0) else $error("digest with partial block");
  sha_rnd_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StRound && st_q != StFold |-> rnd_q == 6'd0 || st_q == StOut
    || st_q == StIdle || st_q == StLoad || st_q == StPad)
    else $error("round counter");

endmodule
`default_nettype wire
